// ===== hw/rtl/nsc_pkg.sv =====
// Package for the NMEA sentence checker: character codes, default sizes,
// the per-byte class record and the result record. No dependencies.
package nsc_pkg;

  localparam int MAX_LEN_DEF     = 128;
  localparam int FIELD_LIMIT_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int PREFIX_LEN = 6;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [7:0] GGA_TEXT [PREFIX_LEN] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
  localparam logic [7:0] RMC_TEXT [PREFIX_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_GGA   = 2'd1;
  localparam logic [1:0] KIND_RMC   = 2'd2;

  typedef struct packed {
    logic [7:0]            data;
    logic                  is_star;
    logic                  is_comma;
    logic                  is_lf;
    logic                  hex_ok;
    logic [3:0]            hex_val;
    logic [PREFIX_LEN-1:0] gga_eq;
    logic [PREFIX_LEN-1:0] rmc_eq;
  } byte_class_t;

  typedef struct packed {
    logic       checksum_ok;
    logic       star_seen;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [4:0] comma_count;
    logic [1:0] sentence_kind;
    logic       truncated;
    logic [6:0] sentence_length;
  } result_t;

endpackage

// ===== hw/rtl/nsc_front.sv =====
// Front end: classifies each received byte (delimiters, hex digit, prefix
// compare per position). Depends on nsc_pkg.
module nsc_front (
  input  logic [7:0]          data_byte,
  output nsc_pkg::byte_class_t cls
);

  always_comb begin
    cls          = '0;
    cls.data     = data_byte;
    cls.is_star  = (data_byte == nsc_pkg::CH_STAR);
    cls.is_comma = (data_byte == nsc_pkg::CH_COMMA);
    cls.is_lf    = (data_byte == nsc_pkg::CH_LF);
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = data_byte[3:0];
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = data_byte[3:0] + 4'd9;
    end
    for (int i = 0; i < nsc_pkg::PREFIX_LEN; i++) begin
      cls.gga_eq[i] = (data_byte == nsc_pkg::GGA_TEXT[i]);
      cls.rmc_eq[i] = (data_byte == nsc_pkg::RMC_TEXT[i]);
    end
  end

endmodule

// ===== hw/rtl/nsc_queue.sv =====
// Short queue between front and back end; power-of-two depth.
// No dependencies.
module nsc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/nsc_back.sv =====
// Back end: per-sentence state (position, checksum, hex parse, commas,
// prefix) and the result register. Depends on nsc_pkg.
module nsc_back #(
  parameter int MAX_LEN     = nsc_pkg::MAX_LEN_DEF,
  parameter int FIELD_LIMIT = nsc_pkg::FIELD_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  nsc_pkg::byte_class_t q_head,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output nsc_pkg::result_t     res
);

  localparam int PW = $clog2(MAX_LEN);
  localparam int CW = $clog2(FIELD_LIMIT);
  localparam logic [1:0] HEX_CLOSED = 2'd3;
  localparam logic [1:0] HEX_TWO    = 2'd2;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic          star_r, star_nxt;
  logic [7:0]    hexv_r, hexv_nxt;
  logic [1:0]    hds_r, hds_nxt;
  logic          long_r, long_nxt;
  logic [CW-1:0] commas_r, commas_nxt;
  logic [1:0]    pm_r, pm_nxt;
  logic          end_sent;
  logic [2:0]    pos_idx;
  logic [1:0]    kind;
  logic [CW+4:0] commas_wide;
  logic [PW+6:0] pos_wide;
  logic          res_valid_r;
  nsc_pkg::result_t res_r, res_nxt;

  always_comb begin
    pos_idx    = pos_r[2:0];
    pm_nxt     = pm_r;
    xor_nxt    = xor_r;
    star_nxt   = star_r;
    hexv_nxt   = hexv_r;
    hds_nxt    = hds_r;
    long_nxt   = long_r;
    commas_nxt = commas_r;

    if (pos_r < PW'(nsc_pkg::PREFIX_LEN)) begin
      if (!q_head.gga_eq[pos_idx]) pm_nxt[0] = 1'b0;
      if (!q_head.rmc_eq[pos_idx]) pm_nxt[1] = 1'b0;
    end

    if (star_r) begin
      if (hds_r != HEX_CLOSED) begin
        if (!q_head.hex_ok) begin
          hds_nxt = HEX_CLOSED;
        end else if (hds_r != HEX_TWO) begin
          hexv_nxt = {hexv_r[3:0], q_head.hex_val};
          hds_nxt  = hds_r + 2'd1;
        end else begin
          long_nxt = 1'b1;
          hds_nxt  = HEX_CLOSED;
        end
      end
    end else if (q_head.is_star) begin
      star_nxt = 1'b1;
    end else if (pos_r != '0) begin
      xor_nxt = xor_r ^ q_head.data;
    end

    if (q_head.is_comma && commas_r != CW'(FIELD_LIMIT - 1)) begin
      commas_nxt = commas_r + CW'(1);
    end

    pos_nxt  = pos_r + PW'(1);
    end_sent = q_head.is_lf || (pos_nxt >= PW'(MAX_LEN - 1));

    kind = nsc_pkg::KIND_OTHER;
    if (pos_nxt >= PW'(nsc_pkg::PREFIX_LEN)) begin
      if (pm_nxt[0] && commas_nxt >= CW'(6)) kind = nsc_pkg::KIND_GGA;
      else if (pm_nxt[1] && commas_nxt >= CW'(7)) kind = nsc_pkg::KIND_RMC;
    end

    commas_wide = (CW+5)'(commas_nxt);
    pos_wide    = (PW+7)'(pos_nxt);

    res_nxt.checksum_ok     = star_nxt && !long_nxt && (xor_nxt == hexv_nxt);
    res_nxt.star_seen       = star_nxt;
    res_nxt.computed_sum    = xor_nxt;
    res_nxt.received_sum    = hexv_nxt;
    res_nxt.comma_count     = commas_wide[4:0];
    res_nxt.sentence_kind   = kind;
    res_nxt.truncated       = !q_head.is_lf;
    res_nxt.sentence_length = pos_wide[6:0];
  end

  assign q_pop     = q_valid && (!end_sent || !res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      xor_r       <= '0;
      star_r      <= 1'b0;
      hexv_r      <= '0;
      hds_r       <= '0;
      long_r      <= 1'b0;
      commas_r    <= '0;
      pm_r        <= 2'b11;
      res_valid_r <= 1'b0;
    end else begin
      if (q_pop && end_sent) begin
        pos_r    <= '0;
        xor_r    <= '0;
        star_r   <= 1'b0;
        hexv_r   <= '0;
        hds_r    <= '0;
        long_r   <= 1'b0;
        commas_r <= '0;
        pm_r     <= 2'b11;
      end else if (q_pop) begin
        pos_r    <= pos_nxt;
        xor_r    <= xor_nxt;
        star_r   <= star_nxt;
        hexv_r   <= hexv_nxt;
        hds_r    <= hds_nxt;
        long_r   <= long_nxt;
        commas_r <= commas_nxt;
        pm_r     <= pm_nxt;
      end
      if (q_pop && end_sent) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && end_sent) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < PW'(MAX_LEN - 1))
    else $error("sentence position past limit");
  a_hex_needs_star: assert property (@(posedge clk) disable iff (!rst_n)
    (hds_r != '0) |-> star_r)
    else $error("hex parse active without star");
  a_long_closes: assert property (@(posedge clk) disable iff (!rst_n)
    long_r |-> (hds_r == HEX_CLOSED))
    else $error("third hex digit left parse open");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && end_sent) |=> (res_valid_r && pos_r == '0 && pm_r == 2'b11))
    else $error("sentence end did not load result and clear state");
  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_ready) |=> (res_valid_r && $stable(res_r)))
    else $error("pending result lost");
`endif

endmodule

// ===== hw/rtl/nmea_sentence_checker_top.sv =====
// NMEA sentence checker, top level: front classifier, queue, back end.
// Depends on nsc_pkg, nsc_front, nsc_queue, nsc_back.
//
// Accepts one received byte per clock while the queue has room and returns
// one result per sentence, at a line feed or after MAX_LEN-1 bytes. Each
// byte is registered in the queue and the sentence result in the back end's
// result register before it reaches the output. The queue of QUEUE_DEPTH
// entries lets input keep flowing while a result waits at the output
// register; input stalls only once that queue fills.
module nmea_sentence_checker_top #(
  parameter int MAX_LEN     = nsc_pkg::MAX_LEN_DEF,
  parameter int FIELD_LIMIT = nsc_pkg::FIELD_LIMIT_DEF,
  parameter int QUEUE_DEPTH = nsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] checksum_ok, [1] star_seen, [9:2] computed_sum, [17:10] received_sum,
  // [22:18] comma_count, [23] truncated, [30:24] sentence_length, [31] zero
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] sentence_kind
);

  localparam int CLS_W = $bits(nsc_pkg::byte_class_t);

  nsc_pkg::byte_class_t cls, head;
  nsc_pkg::result_t     res;
  logic                 q_full, q_valid, q_pop, push;
  logic [CLS_W-1:0]     head_bits;

  nsc_front u_front (
    .data_byte (in_tdata),
    .cls       (cls)
  );

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  nsc_queue #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_bits)
  );

  assign head = nsc_pkg::byte_class_t'(head_bits);

  nsc_back #(
    .MAX_LEN     (MAX_LEN),
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (head),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {1'b0, res.sentence_length, res.truncated, res.comma_count,
                      res.received_sum, res.computed_sum, res.star_seen,
                      res.checksum_ok};
  assign out_tuser = res.sentence_kind;

endmodule
